// ===== sv/spa_pkg.sv =====
package spa_pkg;

  localparam int MAX_TERMS = 64;
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int COEF_W = 32;
  localparam int EXP_W = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_ADD    = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRD,
    S_SCMP,
    S_DECIDE,
    S_SHRD,
    S_SHWR,
    S_WRITE,
    S_RMRD,
    S_RMWR,
    S_DRD,
    S_DWAIT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PTR_DN,
    RD_PTR_UP
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_SUM
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_IN,
    RES_RD,
    RES_SUM
  } res_sel_t;

  typedef enum logic {
    OUT_RESULT,
    OUT_DUMP
  } out_src_t;

  typedef struct packed {
    logic     take;
    logic     idx_clr;
    logic     idx_inc;
    logic     hit_clr;
    logic     hit_ld;
    logic     ptr_from_cnt;
    logic     ptr_from_idx;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     res_load;
    res_sel_t res_sel;
    logic     res_exp_zero;
    status_t  res_status;
    logic     out_load;
    out_src_t out_src;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_full;
    logic lt;
    logic hit;
    logic coef_zero;
    logic sum_zero;
    logic idx_last;
    logic idx_eq_cnt;
    logic ptr_dn_is_idx;
    logic rm_more;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/spa_ctrl.sv =====
module spa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spa_pkg::sts_t sts,
  output spa_pkg::cmd_t cmd
);
  import spa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          cmd.idx_clr = 1'b1;
          cmd.hit_clr = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel = RES_ZERO;
            cmd.res_exp_zero = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt = S_EMIT;
          end
          OP_DUMP: begin
            if (sts.cnt_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel = RES_ZERO;
              cmd.res_exp_zero = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_DRD;
            end
          end
          OP_INSERT, OP_ADD: begin
            state_nxt = sts.cnt_zero ? S_DECIDE : S_SRD;
          end
        endcase
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.hit_ld = 1'b1;
        if (sts.lt) begin
          cmd.idx_inc = 1'b1;
          state_nxt = sts.idx_last ? S_DECIDE : S_SRD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.res_status = ST_OK;
        if (sts.hit) begin
          if (sts.op == OP_INSERT) begin
            cmd.res_load = 1'b1;
            cmd.res_sel = RES_RD;
            state_nxt = S_EMIT;
          end else if (sts.sum_zero) begin
            if (sts.idx_last) begin
              cmd.cnt_dec = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_sel = RES_ZERO;
              state_nxt = S_EMIT;
            end else begin
              cmd.ptr_from_idx = 1'b1;
              state_nxt = S_RMRD;
            end
          end else begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_SUM;
            cmd.res_load = 1'b1;
            cmd.res_sel = RES_SUM;
            state_nxt = S_EMIT;
          end
        end else if (sts.op == OP_ADD && sts.coef_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_nxt = S_EMIT;
        end else if (sts.cnt_full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = RES_ZERO;
          cmd.res_status = ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          cmd.ptr_from_cnt = 1'b1;
          state_nxt = sts.idx_eq_cnt ? S_WRITE : S_SHRD;
        end
      end
      S_SHRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_PTR_DN;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        state_nxt = sts.ptr_dn_is_idx ? S_WRITE : S_SHRD;
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = WR_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel = RES_IN;
        cmd.res_status = ST_OK;
        state_nxt = S_EMIT;
      end
      S_RMRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_PTR_UP;
        state_nxt = S_RMWR;
      end
      S_RMWR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        if (sts.rm_more) begin
          state_nxt = S_RMRD;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel = RES_ZERO;
          cmd.res_status = ST_OK;
          state_nxt = S_EMIT;
        end
      end
      S_DRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src = OUT_DUMP;
          cmd.idx_inc = 1'b1;
          state_nxt = sts.idx_last ? S_IDLE : S_DRD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src = OUT_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/spa_dp.sv =====
module spa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_opcode,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spa_pkg::EXP_W-1:0]   in_exponent,
  input  spa_pkg::cmd_t               cmd,
  output spa_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [spa_pkg::COEF_W-1:0] out_coefficient,
  output logic [spa_pkg::EXP_W-1:0]   out_exponent,
  output logic                        out_last,
  output logic [1:0]                  out_status
);
  import spa_pkg::*;

  logic [COEF_W+EXP_W-1:0] mem [MAX_TERMS];

  op_t                      op_r;
  logic signed [COEF_W-1:0] coef_r;
  logic [EXP_W-1:0]         exp_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            idx_r;
  logic [CW-1:0]            ptr_r;
  logic                     hit_r;
  logic [COEF_W+EXP_W-1:0]  rdata_r;
  logic signed [COEF_W-1:0] res_coef_r;
  logic [EXP_W-1:0]         res_exp_r;
  status_t                  res_status_r;
  logic                     out_valid_r;
  logic signed [COEF_W-1:0] out_coef_r;
  logic [EXP_W-1:0]         out_exp_r;
  logic                     out_last_r;
  status_t                  out_status_r;

  logic signed [COEF_W-1:0] rd_coef;
  logic [EXP_W-1:0]         rd_exp;
  logic signed [COEF_W:0]   sum_wide;
  logic signed [COEF_W-1:0] sum_sat;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [COEF_W+EXP_W-1:0]  wdata;
  logic [CW-1:0]            ptr_dn;
  logic [CW-1:0]            ptr_up;

  assign rd_coef = rdata_r[COEF_W+EXP_W-1:EXP_W];
  assign rd_exp = rdata_r[EXP_W-1:0];
  assign ptr_dn = ptr_r - CW'(1);
  assign ptr_up = ptr_r + CW'(1);

  always_comb begin
    sum_wide = {rd_coef[COEF_W-1], rd_coef} + {coef_r[COEF_W-1], coef_r};
    if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
      sum_sat = sum_wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[COEF_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR_DN: raddr = ptr_dn[AW-1:0];
      RD_PTR_UP: raddr = ptr_up[AW-1:0];
      default:   raddr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_NEW: begin
        waddr = idx_r[AW-1:0];
        wdata = {coef_r, exp_r};
      end
      WR_SUM: begin
        waddr = idx_r[AW-1:0];
        wdata = {sum_sat, exp_r};
      end
      default: begin
        waddr = ptr_r[AW-1:0];
        wdata = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r <= op_t'(in_opcode);
      coef_r <= in_coefficient;
      exp_r <= in_exponent;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.ptr_from_cnt) begin
      ptr_r <= cnt_r;
    end else if (cmd.ptr_from_idx) begin
      ptr_r <= idx_r;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_up;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_dn;
    end
    if (cmd.hit_clr) begin
      hit_r <= 1'b0;
    end else if (cmd.hit_ld) begin
      hit_r <= (rd_exp == exp_r);
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_IN:  res_coef_r <= coef_r;
        RES_RD:  res_coef_r <= rd_coef;
        RES_SUM: res_coef_r <= sum_sat;
        default: res_coef_r <= '0;
      endcase
      res_exp_r <= cmd.res_exp_zero ? '0 : exp_r;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      if (cmd.out_src == OUT_DUMP) begin
        out_coef_r <= rd_coef;
        out_exp_r <= rd_exp;
        out_last_r <= sts.idx_last;
        out_status_r <= ST_OK;
      end else begin
        out_coef_r <= res_coef_r;
        out_exp_r <= res_exp_r;
        out_last_r <= 1'b1;
        out_status_r <= res_status_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op = op_r;
    sts.cnt_zero = (cnt_r == '0);
    sts.cnt_full = (cnt_r == CW'(MAX_TERMS));
    sts.lt = (rd_exp < exp_r);
    sts.hit = hit_r;
    sts.coef_zero = (coef_r == '0);
    sts.sum_zero = (sum_sat == '0);
    sts.idx_last = ((idx_r + CW'(1)) == cnt_r);
    sts.idx_eq_cnt = (idx_r == cnt_r);
    sts.ptr_dn_is_idx = (ptr_dn == idx_r);
    sts.rm_more = ((ptr_r + CW'(2)) < cnt_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_exponent = out_exp_r;
  assign out_last = out_last_r;
  assign out_status = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_TERMS))
    else $error("Term count exceeds table size.");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("Table read and write issued in the same cycle.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("Result register overwritten before its transaction.");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (cnt_r < CW'(MAX_TERMS)))
    else $error("Term stored into a full table.");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |=> ($past(cnt_r) != '0))
    else $error("Term removed from an empty table.");

endmodule

// ===== sv/sparse_polynomial_accumulator.sv =====
// Channel   Ports                                                   Transaction
// input     in_valid, in_ready, in_opcode, in_coefficient,          one opcode
//           in_exponent
// result    out_valid, out_ready, out_coefficient, out_exponent,    one term or result
//           out_last, out_status
//
// Clear does not touch the table. Insert and add scan the stored terms in the single-port term
// table, shifting terms as needed to store a new term or to remove one whose sum is zero.
// Dump reads the stored terms one by one through the table's registered read port.
// Reset clears the term count and the control state; table contents are left as they are.
// A new transaction is taken while the previous result still waits in the output register;
// a stalled result channel holds the controller before it loads the next result.
module sparse_polynomial_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic signed [31:0] in_coefficient,
  input  logic [15:0] in_exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_coefficient,
  output logic [15:0] out_exponent,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import spa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_coefficient  (in_coefficient),
    .in_exponent     (in_exponent),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coefficient (out_coefficient),
    .out_exponent    (out_exponent),
    .out_last        (out_last),
    .out_status      (out_status)
  );

endmodule

// ===== test/tb_sparse_polynomial_accumulator.sv =====
`timescale 1ns / 100ps

module tb_sparse_polynomial_accumulator;
  import spa_pkg::*;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        expo;
    logic               last;
    status_t            status;
  } term_res_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] c;
    logic [15:0]        e;
    logic               typed;
    logic signed [31:0] want_c;
    logic [15:0]        want_e;
    status_t            want_s;
  } plan_row_t;

  localparam int DIRECTED_ROWS = 21;

  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    '{OP_DUMP,   32'sd0,           16'd0,      1'b1, 32'sd0,           16'd0,      ST_EMPTY},
    '{OP_CLEAR,  32'sd0,           16'd0,      1'b1, 32'sd0,           16'd0,      ST_OK},
    '{OP_INSERT, 32'sd5,           16'd100,    1'b1, 32'sd5,           16'd100,    ST_OK},
    '{OP_INSERT, 32'sd7,           16'd100,    1'b1, 32'sd5,           16'd100,    ST_OK},
    '{OP_INSERT, 32'sd0,           16'd0,      1'b1, 32'sd0,           16'd0,      ST_OK},
    '{OP_INSERT, 32'sh7fffffff,    16'hffff,   1'b1, 32'sh7fffffff,    16'hffff,   ST_OK},
    '{OP_ADD,    32'sd1,           16'hffff,   1'b1, 32'sh7fffffff,    16'hffff,   ST_OK},
    '{OP_INSERT, 32'sh80000000,    16'd50,     1'b1, 32'sh80000000,    16'd50,     ST_OK},
    '{OP_ADD,    -32'sd1,          16'd50,     1'b1, 32'sh80000000,    16'd50,     ST_OK},
    '{OP_ADD,    32'sd0,           16'd200,    1'b1, 32'sd0,           16'd200,    ST_OK},
    '{OP_ADD,    32'sd5,           16'd300,    1'b1, 32'sd5,           16'd300,    ST_OK},
    '{OP_ADD,    -32'sd5,          16'd300,    1'b1, 32'sd0,           16'd300,    ST_OK},
    '{OP_ADD,    -32'sd5,          16'd100,    1'b1, 32'sd0,           16'd100,    ST_OK},
    '{OP_DUMP,   32'sd0,           16'd0,      1'b0, 32'sd0,           16'd0,      ST_OK},
    '{OP_INSERT, 32'sh55555555,    16'h5555,   1'b0, 32'sd0,           16'd0,      ST_OK},
    '{OP_ADD,    32'shaaaaaaaa,    16'haaaa,   1'b0, 32'sd0,           16'd0,      ST_OK},
    '{OP_ADD,    32'sh80000000,    16'd50,     1'b1, 32'sh80000000,    16'd50,     ST_OK},
    '{OP_ADD,    32'sh7fffffff,    16'd0,      1'b1, 32'sh7fffffff,    16'd0,      ST_OK},
    '{OP_DUMP,   32'sd0,           16'd0,      1'b0, 32'sd0,           16'd0,      ST_OK},
    '{OP_CLEAR,  32'shffffffff,    16'hffff,   1'b1, 32'sd0,           16'd0,      ST_OK},
    '{OP_DUMP,   32'sd0,           16'd0,      1'b1, 32'sd0,           16'd0,      ST_EMPTY}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic signed [31:0] in_coefficient;
  logic [15:0]        in_exponent;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_coefficient;
  logic [15:0]        out_exponent;
  logic               out_last;
  logic [1:0]         out_status;

  logic signed [31:0] poly_coef [MAX_TERMS];
  logic [15:0]        poly_exp [MAX_TERMS];
  int                 poly_count;

  term_res_t fresh_terms[$];
  term_res_t pending_terms[$];
  int        fail_count;
  bit        quiet;

  sparse_polynomial_accumulator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_coefficient  (in_coefficient),
    .in_exponent     (in_exponent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coefficient (out_coefficient),
    .out_exponent    (out_exponent),
    .out_last        (out_last),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void note_term(logic signed [31:0] c, logic [15:0] e, logic l,
                                    status_t s);
    term_res_t t;
    t.coef = c;
    t.expo = e;
    t.last = l;
    t.status = s;
    fresh_terms.push_back(t);
  endfunction

  function automatic void update_poly(op_t op, logic signed [31:0] c, logic [15:0] e);
    int     pos;
    int     i;
    bit     hit;
    longint sum;
    fresh_terms.delete();
    case (op)
      OP_CLEAR: begin
        poly_count = 0;
        note_term(32'sd0, 16'd0, 1'b1, ST_OK);
      end
      OP_DUMP: begin
        if (poly_count == 0) begin
          note_term(32'sd0, 16'd0, 1'b1, ST_EMPTY);
        end else begin
          for (i = 0; i < poly_count; i++) begin
            note_term(poly_coef[i], poly_exp[i], i == poly_count - 1, ST_OK);
          end
        end
      end
      default: begin
        pos = 0;
        while (pos < poly_count && poly_exp[pos] < e) pos++;
        hit = (pos < poly_count) && (poly_exp[pos] == e);
        if (hit && op == OP_INSERT) begin
          note_term(poly_coef[pos], e, 1'b1, ST_OK);
        end else if (hit) begin
          sum = longint'(poly_coef[pos]) + longint'(c);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          if (sum == 0) begin
            for (i = pos; i + 1 < poly_count; i++) begin
              poly_coef[i] = poly_coef[i + 1];
              poly_exp[i] = poly_exp[i + 1];
            end
            poly_count--;
            note_term(32'sd0, e, 1'b1, ST_OK);
          end else begin
            poly_coef[pos] = 32'(sum);
            note_term(32'(sum), e, 1'b1, ST_OK);
          end
        end else if (op == OP_ADD && c == 0) begin
          note_term(32'sd0, e, 1'b1, ST_OK);
        end else if (poly_count == MAX_TERMS) begin
          note_term(32'sd0, e, 1'b1, ST_FULL);
        end else begin
          for (i = poly_count; i > pos; i--) begin
            poly_coef[i] = poly_coef[i - 1];
            poly_exp[i] = poly_exp[i - 1];
          end
          poly_coef[pos] = c;
          poly_exp[pos] = e;
          poly_count++;
          note_term(c, e, 1'b1, ST_OK);
        end
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4, 5: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_item(input op_t op, input logic signed [31:0] c, input logic [15:0] e,
                          input logic typed, input term_res_t want);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_coefficient <= c;
    in_exponent <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_poly(op, c, e);
    if (typed) begin
      pending_terms.push_back(want);
    end else begin
      foreach (fresh_terms[i]) pending_terms.push_back(fresh_terms[i]);
    end
  endtask

  task automatic random_item(input bit wide);
    int                 r;
    int                 idx;
    op_t                op;
    logic signed [31:0] c;
    logic [15:0]        e;
    r = $urandom_range(0, 99);
    if (r < 4) op = OP_CLEAR;
    else if (r < 40) op = OP_INSERT;
    else if (r < 90) op = OP_ADD;
    else op = OP_DUMP;
    c = rand_coef();
    if (poly_count > 0 && $urandom_range(0, 2) == 0) begin
      idx = $urandom_range(0, poly_count - 1);
      e = poly_exp[idx];
      if (op == OP_ADD && $urandom_range(0, 2) == 0) c = -poly_coef[idx];
    end else if (wide) begin
      e = 16'($urandom_range(0, 65535));
    end else begin
      e = 16'($urandom_range(0, 23));
    end
    run_item(op, c, e, 1'b0, '0);
  endtask

  initial begin
    term_res_t got;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_terms.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got coef %0d exp %0d last %0b status %0d",
                   $time, out_coefficient, out_exponent, out_last, out_status);
          fail_count++;
        end else begin
          got = pending_terms.pop_front();
          if (out_coefficient !== got.coef) begin
            $display("%0t: coefficient mismatch, expected %0d, got %0d",
                     $time, got.coef, out_coefficient);
            fail_count++;
          end
          if (out_exponent !== got.expo) begin
            $display("%0t: exponent mismatch, expected %0d, got %0d",
                     $time, got.expo, out_exponent);
            fail_count++;
          end
          if (out_last !== got.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b", $time, got.last, out_last);
            fail_count++;
          end
          if (out_status !== got.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, got.status, out_status);
            fail_count++;
          end
        end
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    term_res_t want;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_coefficient = 32'sd0;
    in_exponent = 16'd0;
    poly_count = 0;
    fail_count = 0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      want.coef = PLAN[i].want_c;
      want.expo = PLAN[i].want_e;
      want.last = 1'b1;
      want.status = PLAN[i].want_s;
      run_item(PLAN[i].op, PLAN[i].c, PLAN[i].e, PLAN[i].typed, want);
    end

    repeat (87) random_item(1'b0);

    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);

    // Fill the table from the top down so that every insert shifts the whole table.
    quiet = 1'b1;
    run_item(OP_CLEAR, rand_coef(), 16'd0, 1'b0, '0);
    for (int k = MAX_TERMS - 1; k >= 0; k--) begin
      run_item(OP_INSERT, rand_coef(), 16'(k * 1024 + 1 + $urandom_range(0, 1000)),
               1'b0, '0);
    end
    run_item(OP_INSERT, rand_coef(), 16'd0, 1'b0, '0);
    run_item(OP_ADD, 32'sd77, 16'd2048, 1'b0, '0);
    run_item(OP_ADD, 32'sd0, 16'd4096, 1'b0, '0);
    run_item(OP_INSERT, rand_coef(), poly_exp[5], 1'b0, '0);
    run_item(OP_ADD, rand_coef(), poly_exp[10], 1'b0, '0);
    run_item(OP_ADD, -poly_coef[0], poly_exp[0], 1'b0, '0);
    run_item(OP_INSERT, rand_coef(), 16'd0, 1'b0, '0);
    run_item(OP_DUMP, rand_coef(), 16'hffff, 1'b0, '0);
    run_item(OP_ADD, 32'sd3, 16'd1024, 1'b0, '0);
    run_item(OP_DUMP, 32'sd0, 16'd0, 1'b0, '0);
    quiet = 1'b0;

    repeat (87) random_item(1'b1);

    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sparse_polynomial_accumulator.f =====
sv/spa_pkg.sv
sv/spa_ctrl.sv
sv/spa_dp.sv
sv/sparse_polynomial_accumulator.sv
test/tb_sparse_polynomial_accumulator.sv
